// ----- sv/sfd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the SBUS frame decoder.
package sfd_pkg;

    localparam int FRAME_BYTES  = 25;
    localparam int NUM_CHANNELS = 10;
    localparam int POS_W        = 5;
    localparam int CH_W         = 11;
    localparam int IDX_W        = 4;
    localparam int MS_W         = 16;

    // Flag byte and bit positions in a frame
    localparam int FLAG_BYTE = 23;
    localparam int LOST_BIT  = 2;
    localparam int OFF_BIT   = 3;

    localparam logic [MS_W-1:0] MS_MAX = 16'hFFFF;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_TH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARK_TH = 2'd2;
    localparam int CFG_DATA_W = 16;

    localparam logic [MS_W-1:0] TIMEOUT_RST = 16'd100;
    localparam logic [CH_W-1:0] FWD_TH_RST  = 11'd1000;
    localparam logic [CH_W-1:0] PARK_TH_RST = 11'd1500;

    // Throttle: t = floor((1788 - ch) * 100 / 1588) = (d * THR_RECIP) >> THR_SHIFT
    localparam logic [CH_W-1:0] THR_TOP    = 11'd1788;
    localparam logic [21:0]     THR_RECIP  = 22'd2113000;
    localparam int              THR_SHIFT  = 25;
    localparam logic [7:0]      THR_LOW    = 8'd10;
    localparam logic [7:0]      THR_HIGH   = 8'd90;
    localparam logic [6:0]      THR_FULL   = 7'd100;

    // Steering: s = floor((ch - 200) * 180 / 1600) = (e * STR_RECIP) >> STR_SHIFT
    localparam logic [CH_W-1:0] STR_BASE   = 11'd200;
    localparam logic [17:0]     STR_RECIP  = 18'd235935;
    localparam int              STR_SHIFT  = 21;
    localparam logic [7:0]      STR_SNAP_LO = 8'd87;
    localparam logic [7:0]      STR_SNAP_HI = 8'd93;
    localparam logic [7:0]      STR_CENTER = 8'd90;
    localparam logic [7:0]      STR_MAX    = 8'd180;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_TICK = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } sfd_cmd_t;

    typedef struct packed {
        logic [1:0]       command;
        logic [7:0]       data_byte;
        logic             frame_end;
        logic [IDX_W-1:0] channel_index;
    } sfd_in_t;

    typedef struct packed {
        logic [6:0]      throttle_pct;
        logic [7:0]      steering_deg;
        logic            forward;
        logic            parking;
        logic            frame_lost;
        logic            failsafe;
        logic [CH_W-1:0] channel_value;
    } sfd_out_t;

    // Decoded state seen by the result stage
    typedef struct packed {
        logic [CH_W-1:0] ch0;
        logic [CH_W-1:0] ch2;
        logic [CH_W-1:0] ch8;
        logic [CH_W-1:0] ch9;
        logic            lost;
        logic            off;
        logic [MS_W-1:0] elapsed;
    } sfd_status_t;

endpackage

// ----- sv/sfd_frame_state.sv -----
`timescale 1ns / 1ps
// Frame byte store, commit/unpack, channel registers, flags and elapsed-ms counter.
module sfd_frame_state
    import sfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  sfd_in_t          req,
    output sfd_status_t      status,
    output logic [CH_W-1:0]  chval
);

    logic [7:0]       bytes_reg  [FRAME_BYTES];
    logic [7:0]       bytes_next [FRAME_BYTES];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CH_W-1:0]  chan_reg  [NUM_CHANNELS];
    logic [CH_W-1:0]  chan_next [NUM_CHANNELS];
    logic             lost_reg, lost_next;
    logic             off_reg, off_next;
    logic [MS_W-1:0]  elapsed_reg, elapsed_next;
    sfd_cmd_t         cmd;
    logic             commit;

    assign cmd    = sfd_cmd_t'(req.command);
    assign commit = accept && (cmd == CMD_BYTE) && req.frame_end;

    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            bytes_next[i] = bytes_reg[i];
            if (accept && (cmd == CMD_BYTE) && (pos_reg == POS_W'(i)))
            begin
                bytes_next[i] = req.data_byte;
            end
        end

        pos_next = pos_reg;
        if (accept && (cmd == CMD_BYTE) && (pos_reg < POS_W'(FRAME_BYTES)))
        begin
            pos_next = pos_reg + 1'b1;
        end
        if (commit)
        begin
            pos_next = '0;
        end

        elapsed_next = elapsed_reg;
        if (accept && (cmd == CMD_TICK) && (elapsed_reg != MS_MAX))
        begin
            elapsed_next = elapsed_reg + 1'b1;
        end
        if (commit)
        begin
            elapsed_next = '0;
        end

        // Standard SBUS 11-bit packing, LSB first from byte 1
        chan_next[0] = {bytes_next[2][2:0],  bytes_next[1]};
        chan_next[1] = {bytes_next[3][5:0],  bytes_next[2][7:3]};
        chan_next[2] = {bytes_next[5][0],    bytes_next[4], bytes_next[3][7:6]};
        chan_next[3] = {bytes_next[6][3:0],  bytes_next[5][7:1]};
        chan_next[4] = {bytes_next[7][6:0],  bytes_next[6][7:4]};
        chan_next[5] = {bytes_next[9][1:0],  bytes_next[8], bytes_next[7][7]};
        chan_next[6] = {bytes_next[10][4:0], bytes_next[9][7:2]};
        chan_next[7] = {bytes_next[11],      bytes_next[10][7:5]};
        chan_next[8] = {bytes_next[13][2:0], bytes_next[12]};
        chan_next[9] = {bytes_next[14][5:0], bytes_next[13][7:3]};
        lost_next    = bytes_next[FLAG_BYTE][LOST_BIT];
        off_next     = bytes_next[FLAG_BYTE][OFF_BIT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                bytes_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                chan_reg[i] <= '0;
            end
            pos_reg     <= '0;
            lost_reg    <= 1'b0;
            off_reg     <= 1'b0;
            elapsed_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                bytes_reg[i] <= bytes_next[i];
            end
            if (commit)
            begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    chan_reg[i] <= chan_next[i];
                end
                lost_reg <= lost_next;
                off_reg  <= off_next;
            end
            pos_reg     <= pos_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // Channel read; reads never change state, so the stored value is current
    always_comb
    begin
        chval = '0;
        if ((cmd == CMD_READ) && (req.channel_index < IDX_W'(NUM_CHANNELS)))
        begin
            chval = chan_reg[req.channel_index];
        end
    end

    assign status.ch0     = chan_reg[0];
    assign status.ch2     = chan_reg[2];
    assign status.ch8     = chan_reg[8];
    assign status.ch9     = chan_reg[9];
    assign status.lost    = lost_reg;
    assign status.off     = off_reg;
    assign status.elapsed = elapsed_reg;

endmodule

// ----- sv/sfd_result_stage.sv -----
`timescale 1ns / 1ps
// Request-pending stage, control mapping and output register with stall handling.
module sfd_result_stage
    import sfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             accept,
    input  logic [CH_W-1:0]  chval,
    input  sfd_status_t      status,
    input  logic [MS_W-1:0]  timeout_ms,
    input  logic [CH_W-1:0]  fwd_th,
    input  logic [CH_W-1:0]  park_th,
    output logic             out_valid,
    input  logic             out_stall,
    output sfd_out_t         out_data
);

    logic            pend_reg, pend_next;
    logic [CH_W-1:0] chval_reg;
    logic            oval_reg, oval_next;
    sfd_out_t        odata_reg;
    sfd_out_t        res;
    logic            out_free;
    logic            adv;

    logic [CH_W-1:0] thr_d;
    logic [32:0]     thr_prod;
    logic [7:0]      thr_q;
    logic [CH_W-1:0] str_e;
    logic [28:0]     str_prod;
    logic [7:0]      str_q;

    assign out_free = !oval_reg || !out_stall;
    assign adv      = pend_reg && out_free;
    assign in_stall = pend_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    assign pend_next = accept || (pend_reg && !adv);
    assign oval_next = adv || (oval_reg && out_stall);

    // Maps run on the state left by the pending request
    always_comb
    begin
        thr_d    = THR_TOP - status.ch2;
        thr_prod = 33'(thr_d) * 33'(THR_RECIP);
        thr_q    = thr_prod[THR_SHIFT +: 8];
        if (status.ch2 >= THR_TOP || thr_q < THR_LOW)
        begin
            res.throttle_pct = '0;
        end
        else if (thr_q > THR_HIGH)
        begin
            res.throttle_pct = THR_FULL;
        end
        else
        begin
            res.throttle_pct = thr_q[6:0];
        end

        str_e    = status.ch0 - STR_BASE;
        str_prod = 29'(str_e) * 29'(STR_RECIP);
        str_q    = str_prod[STR_SHIFT +: 8];
        if (status.ch0 <= STR_BASE)
        begin
            res.steering_deg = '0;
        end
        else if (str_q > STR_SNAP_LO && str_q < STR_SNAP_HI)
        begin
            res.steering_deg = STR_CENTER;
        end
        else if (str_q > STR_MAX)
        begin
            res.steering_deg = STR_MAX;
        end
        else
        begin
            res.steering_deg = str_q;
        end

        res.forward       = status.ch9 < fwd_th;
        res.parking       = status.ch8 > park_th;
        res.frame_lost    = status.lost;
        res.failsafe      = (status.elapsed > timeout_ms) || status.off;
        res.channel_value = chval_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            oval_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            chval_reg <= chval;
        end
        if (adv)
        begin
            odata_reg <= res;
        end
    end

    assign out_valid = oval_reg;
    assign out_data  = odata_reg;

endmodule

// ----- sv/sbus_frame_decoder.sv -----
`timescale 1ns / 1ps
// SBUS frame decoder top level: configuration registers and stage wiring.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------
//  in      | in_valid/in_stall  | in_data: command, byte, frame_end, index
//  out     | out_valid/out_stall| out_data: controls, flags, channel value
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// One request per cycle sustained while the output is not stalled; a taken request
// updates the state and the pending stage, then the mapped result is registered at the output.
// The throttle and steering maps each use one constant multiply in the result stage.
// Reset clears the byte store, channels, flags, elapsed count and config to defaults.
// A stalled output holds the pending request; the input stalls only when the
// pending stage is full and the output register is full and stalled.
module sbus_frame_decoder
    import sfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sfd_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sfd_out_t              out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [MS_W-1:0] timeout_reg;
    logic [CH_W-1:0] fwd_th_reg;
    logic [CH_W-1:0] park_th_reg;
    logic            accept;
    logic [CH_W-1:0] chval;
    sfd_status_t     status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            fwd_th_reg  <= FWD_TH_RST;
            park_th_reg <= PARK_TH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_data[MS_W-1:0];
                CFG_FWD_TH:  fwd_th_reg  <= cfg_data[CH_W-1:0];
                CFG_PARK_TH: park_th_reg <= cfg_data[CH_W-1:0];
                default:     ;
            endcase
        end
    end

    sfd_frame_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (in_data),
        .status (status),
        .chval  (chval)
    );

    sfd_result_stage u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .accept     (accept),
        .chval      (chval),
        .status     (status),
        .timeout_ms (timeout_reg),
        .fwd_th     (fwd_th_reg),
        .park_th    (park_th_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

// ----- tb/sbus_frame_decoder_checker.sv -----
`timescale 1ns / 1ps
// Watches the decoder channels, predicts each control result and compares it.
module sbus_frame_decoder_checker
    import sfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  sfd_in_t               in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  sfd_out_t              out_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           fail_count,
    output int unsigned           awaited
);

    logic [7:0]      frame_store [FRAME_BYTES];
    int unsigned     store_pos;
    logic [CH_W-1:0] chan [NUM_CHANNELS];
    logic            lost_flag;
    logic            off_flag;
    logic [MS_W-1:0] ms_since_frame;
    logic [MS_W-1:0] timeout_ms;
    logic [CH_W-1:0] fwd_level;
    logic [CH_W-1:0] park_level;
    sfd_out_t        controls_due [$];
    sfd_out_t        want;
    int unsigned     mismatches;

    function automatic logic [6:0] throttle_of_channel(logic [CH_W-1:0] ch);
        int t;
        if (int'(ch) >= 1788)
            return 7'd0;
        t = ((1788 - int'(ch)) * 100) / 1588;
        if (t < 10)
            return 7'd0;
        if (t > 90)
            return 7'd100;
        return 7'(t);
    endfunction

    function automatic logic [7:0] steering_of_channel(logic [CH_W-1:0] ch);
        int s;
        if (int'(ch) <= 200)
            return 8'd0;
        s = ((int'(ch) - 200) * 180) / 1600;
        // center deadband
        if (s > 87 && s < 93)
            s = 90;
        if (s > 180)
            s = 180;
        return 8'(s);
    endfunction

    // Updates the decoder state with one request and returns the controls it yields.
    function automatic sfd_out_t predict_controls(sfd_in_t req);
        sfd_out_t r;
        logic [111:0] packed_bits;
        r = '0;
        case (sfd_cmd_t'(req.command))
            CMD_BYTE:
            begin
                if (store_pos < FRAME_BYTES)
                begin
                    frame_store[store_pos] = req.data_byte;
                    store_pos++;
                end
                if (req.frame_end)
                begin
                    // channels are packed LSB first from byte 1 on
                    for (int i = 0; i < 14; i++)
                        packed_bits[8*i +: 8] = frame_store[i+1];
                    for (int k = 0; k < NUM_CHANNELS; k++)
                        chan[k] = packed_bits[CH_W*k +: CH_W];
                    lost_flag = frame_store[FLAG_BYTE][LOST_BIT];
                    off_flag = frame_store[FLAG_BYTE][OFF_BIT];
                    ms_since_frame = '0;
                    store_pos = 0;
                end
            end
            CMD_TICK:
            begin
                if (ms_since_frame != MS_MAX)
                    ms_since_frame++;
            end
            CMD_READ:
            begin
                if (req.channel_index < NUM_CHANNELS)
                    r.channel_value = chan[req.channel_index];
            end
            default: ;
        endcase
        r.throttle_pct = throttle_of_channel(chan[2]);
        r.steering_deg = steering_of_channel(chan[0]);
        r.forward = chan[9] < fwd_level;
        r.parking = chan[8] > park_level;
        r.frame_lost = lost_flag;
        r.failsafe = (ms_since_frame > timeout_ms) || off_flag;
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
        if (act_val !== exp_val)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %0d, actual %0d", name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_BYTES; i++)
                frame_store[i] = '0;
            for (int k = 0; k < NUM_CHANNELS; k++)
                chan[k] = '0;
            store_pos = 0;
            lost_flag = 1'b0;
            off_flag = 1'b0;
            ms_since_frame = '0;
            timeout_ms = TIMEOUT_RST;
            fwd_level = FWD_TH_RST;
            park_level = PARK_TH_RST;
            controls_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (controls_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with no request pending: %h", out_data);
                end
                else
                begin
                    want = controls_due.pop_front();
                    check_field("throttle_pct", 16'(want.throttle_pct),
                                16'(out_data.throttle_pct));
                    check_field("steering_deg", 16'(want.steering_deg),
                                16'(out_data.steering_deg));
                    check_field("forward", 16'(want.forward), 16'(out_data.forward));
                    check_field("parking", 16'(want.parking), 16'(out_data.parking));
                    check_field("frame_lost", 16'(want.frame_lost), 16'(out_data.frame_lost));
                    check_field("failsafe", 16'(want.failsafe), 16'(out_data.failsafe));
                    check_field("channel_value", 16'(want.channel_value),
                                16'(out_data.channel_value));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TIMEOUT: timeout_ms = cfg_data[MS_W-1:0];
                    CFG_FWD_TH:  fwd_level = cfg_data[CH_W-1:0];
                    CFG_PARK_TH: park_level = cfg_data[CH_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                controls_due.push_back(predict_controls(in_data));
        end
        fail_count <= mismatches;
        awaited <= controls_due.size();
    end

endmodule

// ----- tb/sbus_frame_decoder_tb.sv -----
`timescale 1ns / 1ps
// Stimulus, clock, reset and verdict for the SBUS frame decoder.
module sbus_frame_decoder_tb;
    import sfd_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    sfd_in_t               in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    sfd_out_t              out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_TIMEOUT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int unsigned           fail_count;
    int unsigned           awaited;

    int send_idle = 0;
    int stall_pct = 0;
    int sent = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;
    logic [CH_W-1:0] cur_fwd = FWD_TH_RST;
    logic [CH_W-1:0] cur_park = PARK_TH_RST;

    // channel values around the map break points
    int edge_vals [21] = '{0, 1, 199, 200, 201, 342, 343, 982, 983, 1026, 1027,
                           1500, 1629, 1630, 1787, 1788, 1789, 1808, 1809, 2046, 2047};

    sbus_frame_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sbus_frame_decoder_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .awaited    (awaited)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic send_request(sfd_cmd_t cmd, logic [7:0] data, logic fend, logic [3:0] idx);
        sfd_in_t r;
        r.command = cmd;
        r.data_byte = data;
        r.frame_end = fend;
        r.channel_index = idx;
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic configure(logic [15:0] t, logic [15:0] f, logic [15:0] p);
        drain();
        write_reg(CFG_TIMEOUT, t);
        write_reg(CFG_FWD_TH, f);
        write_reg(CFG_PARK_TH, p);
        write_reg(CFG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
        cur_fwd = f[CH_W-1:0];
        cur_park = p[CH_W-1:0];
    endtask

    // Sends len bytes of a frame image; frame_end on the last one if with_end.
    task automatic send_frame(int len, bit with_end);
        logic [111:0] chan_bits;
        logic [7:0]   image [FRAME_BYTES];
        int           v;
        chan_bits = {$urandom, $urandom, $urandom, $urandom};
        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            case ($urandom_range(0, 3))
                0: v = edge_vals[$urandom_range(0, 20)];
                1: v = int'(k == 8 ? cur_park : k == 9 ? cur_fwd : 11'd1000)
                       + $urandom_range(0, 2) - 1;
                default: v = $urandom_range(0, 2047);
            endcase
            chan_bits[CH_W*k +: CH_W] = CH_W'(v);
        end
        image[0] = 8'h0F;
        for (int i = 1; i < FRAME_BYTES; i++)
            image[i] = 8'($urandom);
        for (int i = 1; i <= 14; i++)
            image[i] = chan_bits[8*(i-1) +: 8];
        image[FLAG_BYTE] = {4'($urandom), ($urandom_range(0, 3) == 0),
                            ($urandom_range(0, 3) == 0), 2'($urandom)};
        for (int i = 0; i < len; i++)
            send_request(CMD_BYTE, (i < FRAME_BYTES) ? image[i] : 8'($urandom),
                         with_end && (i == len - 1), 4'($urandom));
    endtask

    // Mostly well-formed frames with ticks and reads between them, plus
    // short, overflowing and unterminated frames and unused commands.
    task automatic run_random(int n, int idle, int stall);
        int stop;
        int pick;
        int burst;
        stop = sent + n;
        send_idle = idle;
        stall_pct <= stall;
        while (sent < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_frame(FRAME_BYTES, 1'b1);
            else if (pick < 68)
            begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 6);
                repeat (burst)
                    send_request(CMD_TICK, 8'($urandom), 1'($urandom), 4'($urandom));
            end
            else if (pick < 82)
                send_request(CMD_READ, 8'($urandom), 1'($urandom), 4'($urandom));
            else if (pick < 94)
                send_frame($urandom_range(0, 1) ? $urandom_range(1, 24) : $urandom_range(26, 32),
                           $urandom_range(0, 3) != 0);
            else
                send_request(CMD_NONE, 8'($urandom), 1'($urandom), 4'($urandom));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults after reset, ignored frame_end on other commands, a short frame
        send_request(CMD_READ, 8'h00, 1'b0, 4'd0);
        send_request(CMD_READ, 8'hFF, 1'b1, 4'd15);
        send_request(CMD_TICK, 8'hFF, 1'b1, 4'd9);
        send_request(CMD_NONE, 8'hA5, 1'b1, 4'd2);
        send_request(CMD_BYTE, 8'h0F, 1'b0, 4'd0);
        send_request(CMD_BYTE, 8'hFF, 1'b0, 4'd15);
        send_request(CMD_BYTE, 8'hFF, 1'b1, 4'd0);
        send_request(CMD_READ, 8'h00, 1'b0, 4'd0);
        send_request(CMD_READ, 8'h00, 1'b0, 4'd1);
        send_request(CMD_READ, 8'h00, 1'b0, 4'd2);
        send_request(CMD_READ, 8'h00, 1'b0, 4'd10);

        configure(16'd0, 16'd0, 16'd0);
        run_random(360, 0, 0);
        configure(16'd65534, 16'hFFFF, 16'd2047);
        run_random(360, 75, 0);
        configure(16'($urandom_range(0, 300)), 16'($urandom), 16'($urandom));
        run_random(360, 0, 75);
        configure(16'd20, 16'd1000, 16'd1500);
        run_random(360, 12, 12);

        // long receiver hold-off while requests keep coming
        stall_pct <= 0;
        hold_token <= hold_token + 1;
        send_idle = 0;
        repeat (40)
            send_request(CMD_READ, 8'($urandom), 1'($urandom), 4'($urandom));
        drain();

        configure(16'd100, 16'($urandom_range(0, 2047)), 16'($urandom_range(0, 2047)));
        run_random(400, 0, 0);

        // elapsed count running past the timeout, then cleared by a new frame
        configure(16'd150, 16'd1000, 16'd1500);
        send_idle = 0;
        stall_pct <= 0;
        send_frame(FRAME_BYTES, 1'b1);
        repeat (200)
            send_request(CMD_TICK, 8'($urandom), 1'($urandom), 4'($urandom));
        send_request(CMD_READ, 8'h00, 1'b0, 4'd0);
        send_frame(FRAME_BYTES, 1'b1);
        send_request(CMD_TICK, 8'h00, 1'b0, 4'd0);

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && awaited == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
